### rtl/assert_macros.svh
// Assertion macros used by the top level of the cursor layout block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`else

`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

### rtl/tccl_pkg.sv
// Shared types and constants of the text console cursor layout block.
package tccl_pkg;

  localparam int COORD_W    = 13;
  localparam int CODE_W     = 21;
  localparam int GW_W       = 8;
  localparam int WIN_W      = 12;
  localparam int LH_W       = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;
  localparam int KIND_W     = 3;

  localparam logic [COORD_W-1:0] COORD_MAX = 13'h1FFF;
  localparam int                 TAB_SPACES = 8;

  // Control characters
  localparam logic [CODE_W-1:0] CHAR_NEWLINE   = 21'd10;
  localparam logic [CODE_W-1:0] CHAR_RETURN    = 21'd13;
  localparam logic [CODE_W-1:0] CHAR_TAB       = 21'd9;
  localparam logic [CODE_W-1:0] CHAR_BACKSPACE = 21'd8;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WIN_LEFT    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIN_TOP     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WIN_RIGHT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WIN_BOTTOM  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_HEIGHT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SPACE_WIDTH = 3'd5;

  // Register reset values
  localparam logic [WIN_W-1:0] RST_WIN_LEFT    = 12'd29;
  localparam logic [WIN_W-1:0] RST_WIN_TOP     = 12'd55;
  localparam logic [WIN_W-1:0] RST_WIN_RIGHT   = 12'd730;
  localparam logic [WIN_W-1:0] RST_WIN_BOTTOM  = 12'd535;
  localparam logic [LH_W-1:0]  RST_LINE_HEIGHT = 8'd16;
  localparam logic [LH_W-1:0]  RST_SPACE_WIDTH = 8'd8;

  // Character classes
  localparam logic [KIND_W-1:0] KIND_NEWLINE   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_RETURN    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_TAB       = 3'd2;
  localparam logic [KIND_W-1:0] KIND_BACKSPACE = 3'd3;
  localparam logic [KIND_W-1:0] KIND_PRINT     = 3'd4;

  // Commands from controller to datapath
  typedef struct packed {
    logic capture;
    logic newline;
    logic car_ret;
    logic push;
    logic div_start;
    logic tab_fin;
    logic bs_pop;
    logic bs_fin;
    logic draw;
    logic load_out;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              wrap;
    logic              stack_empty;
    logic              div_done;
  } status_t;

endpackage

### rtl/tccl_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tccl_ram #(
  parameter int WIDTH = 13,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/tccl_div.sv
// Restoring divider, one quotient bit a cycle, for the tab stop column.
module tccl_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [tccl_pkg::COORD_W-1:0]  dividend,
  input  logic [tccl_pkg::GW_W-1:0]     divisor,
  output logic                          done,
  output logic [2:0]                    quot_low
);

  localparam int N     = tccl_pkg::COORD_W;
  localparam int DW    = tccl_pkg::GW_W;
  localparam int CNT_W = $clog2(N);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DW-1:0]    rem;
  logic [DW-1:0]    dvs;
  logic [N-1:0]     quot;
  logic [DW:0]      trial;
  logic             fits;

  // Shift the next dividend bit into the partial remainder and test it
  always_comb begin
    trial = {rem, quot[N-1]};
    fits  = (trial >= {1'b0, dvs});
  end

  // Iterate over the dividend bits, most significant first
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(N - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Remainder and quotient shift register
  always_ff @(posedge clk) begin
    if (start) begin
      quot <= dividend;
      rem  <= '0;
      dvs  <= divisor;
    end else if (busy) begin
      quot <= {quot[N-2:0], fits};
      rem  <= fits ? DW'(trial - {1'b0, dvs}) : trial[DW-1:0];
    end
  end

  assign quot_low = quot[2:0];

endmodule

### rtl/tccl_dp.sv
// Datapath: configuration, cursor, x stack, result building and output register.
module tccl_dp #(
  parameter int HISTORY_DEPTH = 256,
  parameter int SCROLL_LINES  = 8
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [tccl_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [tccl_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic [tccl_pkg::CODE_W-1:0]        char_code,
  input  logic [tccl_pkg::GW_W-1:0]          glyph_width,
  input  tccl_pkg::cmd_t                     cmd,
  output tccl_pkg::status_t                  status,
  output logic                               scrolled,
  output logic                               clear_valid,
  output logic [tccl_pkg::COORD_W-1:0]       clear_left,
  output logic [tccl_pkg::COORD_W-1:0]       clear_top,
  output logic [tccl_pkg::COORD_W-1:0]       clear_right,
  output logic [tccl_pkg::COORD_W-1:0]       clear_bottom,
  output logic                               glyph_valid,
  output logic [tccl_pkg::COORD_W-1:0]       glyph_x,
  output logic [tccl_pkg::COORD_W-1:0]       glyph_y
);

  localparam int CW    = tccl_pkg::COORD_W;
  localparam int SW    = CW + 1;
  localparam int AW    = $clog2(HISTORY_DEPTH);
  localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);
  localparam int SC_W  = $clog2(SCROLL_LINES * 255 + 1);
  localparam int YW    = (SC_W > SW) ? SC_W : SW;

  function automatic logic [CW-1:0] sat_coord(input logic [SW-1:0] v);
    logic [CW-1:0] r;
    r = v[SW-1] ? tccl_pkg::COORD_MAX : v[CW-1:0];
    return r;
  endfunction

  // Configuration registers; the top bound only sets the cursor row at reset
  logic [tccl_pkg::WIN_W-1:0] win_left, win_right, win_bottom;
  logic [tccl_pkg::LH_W-1:0]  line_height, space_width;

  // Cursor state and stack fill
  logic [CW-1:0]    cursor_x, cursor_y;
  logic [CNT_W-1:0] hist_count;

  // Captured item
  logic [tccl_pkg::CODE_W-1:0] code_r;
  logic [tccl_pkg::GW_W-1:0]   gw_r;

  // Result under construction
  logic          res_scrolled, res_cv, res_gv;
  logic [CW-1:0] res_cl, res_ct, res_cr, res_cb, res_gx, res_gy;

  // Combinational terms
  logic [SW-1:0]               y_sum;
  logic                        nl_scroll;
  logic [SC_W-1:0]             scroll_amt;
  logic [YW-1:0]               y_wide, amt_wide, y_nl_wide;
  logic [CW-1:0]               y_nl;
  logic [CW-1:0]               line_bottom;
  logic [CW-1:0]               tab_off;
  logic [tccl_pkg::GW_W-1:0]   w_eff;
  logic [3:0]                  tab_steps;
  logic [11:0]                 tab_span;
  logic [CW-1:0]               tab_right, draw_right;
  logic [CNT_W-1:0]            cnt_dec;
  logic [2:0]                  quot_low;
  logic                        div_done;
  logic [CW-1:0]               hist_rdata;

  // Classify the captured character and report status
  always_comb begin
    if (code_r == tccl_pkg::CHAR_NEWLINE) begin
      status.kind = tccl_pkg::KIND_NEWLINE;
    end else if (code_r == tccl_pkg::CHAR_RETURN) begin
      status.kind = tccl_pkg::KIND_RETURN;
    end else if (code_r == tccl_pkg::CHAR_TAB) begin
      status.kind = tccl_pkg::KIND_TAB;
    end else if (code_r == tccl_pkg::CHAR_BACKSPACE) begin
      status.kind = tccl_pkg::KIND_BACKSPACE;
    end else begin
      status.kind = tccl_pkg::KIND_PRINT;
    end
    // Wrap when the glyph would reach the right bound
    status.wrap        = ({1'b0, cursor_x} + SW'(gw_r)) >= SW'(win_right);
    status.stack_empty = (hist_count == '0);
    status.div_done    = div_done;
  end

  // Newline: scroll up when the next line reaches the bottom bound
  always_comb begin
    y_sum       = {1'b0, cursor_y} + SW'(line_height);
    nl_scroll   = y_sum >= SW'(win_bottom);
    scroll_amt  = SC_W'(SCROLL_LINES) * SC_W'(line_height);
    y_wide      = YW'(y_sum);
    amt_wide    = YW'(scroll_amt);
    if (nl_scroll) begin
      y_nl_wide = (y_wide > amt_wide) ? (y_wide - amt_wide) : '0;
    end else begin
      y_nl_wide = y_wide;
    end
    y_nl        = (y_nl_wide > YW'(tccl_pkg::COORD_MAX)) ? tccl_pkg::COORD_MAX
                                                         : y_nl_wide[CW-1:0];
    line_bottom = sat_coord(y_sum);
  end

  // Tab stop and glyph cell extents
  always_comb begin
    w_eff      = (space_width == '0) ? tccl_pkg::GW_W'(1) : space_width;
    tab_off    = (cursor_x >= CW'(win_left)) ? (cursor_x - CW'(win_left)) : '0;
    tab_steps  = 4'(tccl_pkg::TAB_SPACES) - {1'b0, quot_low};
    tab_span   = 12'(tab_steps) * 12'(w_eff);
    tab_right  = sat_coord({1'b0, cursor_x} + SW'(tab_span));
    draw_right = sat_coord({1'b0, cursor_x} + SW'(gw_r));
    cnt_dec    = hist_count - CNT_W'(1);
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      win_left    <= tccl_pkg::RST_WIN_LEFT;
      win_right   <= tccl_pkg::RST_WIN_RIGHT;
      win_bottom  <= tccl_pkg::RST_WIN_BOTTOM;
      line_height <= tccl_pkg::RST_LINE_HEIGHT;
      space_width <= tccl_pkg::RST_SPACE_WIDTH;
    end else if (cfg_we) begin
      case (cfg_index)
        tccl_pkg::CFG_WIN_LEFT:    win_left    <= cfg_data;
        tccl_pkg::CFG_WIN_RIGHT:   win_right   <= cfg_data;
        tccl_pkg::CFG_WIN_BOTTOM:  win_bottom  <= cfg_data;
        tccl_pkg::CFG_LINE_HEIGHT: line_height <= cfg_data[tccl_pkg::LH_W-1:0];
        tccl_pkg::CFG_SPACE_WIDTH: space_width <= cfg_data[tccl_pkg::LH_W-1:0];
        default: ;
      endcase
    end
  end

  // Cursor and stack fill
  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_x   <= CW'(tccl_pkg::RST_WIN_LEFT);
      cursor_y   <= CW'(tccl_pkg::RST_WIN_TOP);
      hist_count <= '0;
    end else begin
      if (cmd.capture && (hist_count >= CNT_W'(HISTORY_DEPTH))) begin
        hist_count <= '0;
      end
      if (cmd.newline) begin
        cursor_y   <= y_nl;
        cursor_x   <= CW'(win_left);
        hist_count <= '0;
      end
      if (cmd.car_ret) begin
        cursor_x   <= CW'(win_left);
        hist_count <= '0;
      end
      if (cmd.push) begin
        hist_count <= hist_count + CNT_W'(1);
      end
      if (cmd.bs_pop) begin
        hist_count <= cnt_dec;
      end
      if (cmd.bs_fin) begin
        cursor_x <= hist_rdata;
      end
      if (cmd.tab_fin) begin
        cursor_x <= tab_right;
      end
      if (cmd.draw) begin
        cursor_x <= draw_right;
      end
    end
  end

  // Capture the item and build its result
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      code_r       <= char_code;
      gw_r         <= glyph_width;
      res_scrolled <= 1'b0;
      res_cv       <= 1'b0;
      res_gv       <= 1'b0;
      res_cl       <= '0;
      res_ct       <= '0;
      res_cr       <= '0;
      res_cb       <= '0;
      res_gx       <= '0;
      res_gy       <= '0;
    end
    if (cmd.newline) begin
      res_scrolled <= nl_scroll;
    end
    if (cmd.bs_fin) begin
      res_cv <= 1'b1;
      res_cl <= hist_rdata;
      res_ct <= cursor_y;
      res_cr <= cursor_x;
      res_cb <= line_bottom;
    end
    if (cmd.tab_fin) begin
      res_cv <= 1'b1;
      res_cl <= cursor_x;
      res_ct <= cursor_y;
      res_cr <= tab_right;
      res_cb <= line_bottom;
    end
    if (cmd.draw) begin
      res_cv <= 1'b1;
      res_cl <= cursor_x;
      res_ct <= cursor_y;
      res_cr <= draw_right;
      res_cb <= line_bottom;
      res_gv <= 1'b1;
      res_gx <= cursor_x;
      res_gy <= cursor_y;
    end
  end

  // Output register, loaded once the previous result has gone
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      scrolled     <= res_scrolled;
      clear_valid  <= res_cv;
      clear_left   <= res_cl;
      clear_top    <= res_ct;
      clear_right  <= res_cr;
      clear_bottom <= res_cb;
      glyph_valid  <= res_gv;
      glyph_x      <= res_gx;
      glyph_y      <= res_gy;
    end
  end

  // Stack of earlier x positions
  tccl_ram #(
    .WIDTH (CW),
    .DEPTH (HISTORY_DEPTH)
  ) u_hist (
    .clk   (clk),
    .we    (cmd.push),
    .waddr (hist_count[AW-1:0]),
    .wdata (cursor_x),
    .re    (cmd.bs_pop),
    .raddr (cnt_dec[AW-1:0]),
    .rdata (hist_rdata)
  );

  // Tab column divider
  tccl_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (tab_off),
    .divisor  (w_eff),
    .done     (div_done),
    .quot_low (quot_low)
  );

endmodule

### rtl/tccl_ctrl.sv
// Controller: sequences one character through the datapath and drives the handshakes.
module tccl_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              char_valid,
  output logic              char_stall,
  output logic              result_valid,
  input  logic              result_stall,
  input  tccl_pkg::status_t status,
  output tccl_pkg::cmd_t    cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_DIV    = 3'd2;
  localparam logic [2:0] S_TABFIN = 3'd3;
  localparam logic [2:0] S_BSRD   = 3'd4;
  localparam logic [2:0] S_DRAW   = 3'd5;
  localparam logic [2:0] S_OUT    = 3'd6;

  logic [2:0] state, state_next;

  assign char_stall = (state != S_IDLE);

  // Next state and commands
  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (char_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_DECODE;
        end
      end
      S_DECODE: begin
        case (status.kind)
          tccl_pkg::KIND_NEWLINE: begin
            cmd.newline = 1'b1;
            state_next  = S_OUT;
          end
          tccl_pkg::KIND_RETURN: begin
            cmd.car_ret = 1'b1;
            state_next  = S_OUT;
          end
          tccl_pkg::KIND_TAB: begin
            cmd.push      = 1'b1;
            cmd.div_start = 1'b1;
            state_next    = S_DIV;
          end
          tccl_pkg::KIND_BACKSPACE: begin
            if (status.stack_empty) begin
              state_next = S_OUT;
            end else begin
              cmd.bs_pop = 1'b1;
              state_next = S_BSRD;
            end
          end
          tccl_pkg::KIND_PRINT: begin
            cmd.newline = status.wrap;
            state_next  = S_DRAW;
          end
          default: state_next = S_OUT;
        endcase
      end
      S_DIV: begin
        if (status.div_done) begin
          state_next = S_TABFIN;
        end
      end
      S_TABFIN: begin
        cmd.tab_fin = 1'b1;
        state_next  = S_OUT;
      end
      S_BSRD: begin
        cmd.bs_fin = 1'b1;
        state_next = S_OUT;
      end
      S_DRAW: begin
        cmd.push   = 1'b1;
        cmd.draw   = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (!result_valid || !result_stall) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // State and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

endmodule

### rtl/text_console_cursor_layout.sv
// Top level of the text console cursor layout block.
//
//   channel  | handshake                  | payload
//   ---------+----------------------------+-------------------------------------------
//   char     | char_valid / char_stall    | char_code, glyph_width
//   result   | result_valid / result_stall| scrolled, clear_*, glyph_valid, glyph_x/y
//   config   | cfg_we                     | cfg_index, cfg_data
//
// One character at a time. Newline, return and a backspace on an empty stack pass through
// decode and output; printable characters and backspace add a draw or stack read state,
// and tab adds a divide state, held by the one-bit-a-cycle divider, and a finish state.
// A finished result waits in the output register while the next character transfers.
// Reset is synchronous; the x stack memory needs no clearing pass.
// A stall on the result side holds the controller only once it has a new result to load.
`include "assert_macros.svh"

module text_console_cursor_layout #(
  parameter int HISTORY_DEPTH = 256,
  parameter int SCROLL_LINES  = 8
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [tccl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tccl_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            char_valid,
  output logic                            char_stall,
  input  logic [tccl_pkg::CODE_W-1:0]     char_code,
  input  logic [tccl_pkg::GW_W-1:0]       glyph_width,
  output logic                            result_valid,
  input  logic                            result_stall,
  output logic                            scrolled,
  output logic                            clear_valid,
  output logic [tccl_pkg::COORD_W-1:0]    clear_left,
  output logic [tccl_pkg::COORD_W-1:0]    clear_top,
  output logic [tccl_pkg::COORD_W-1:0]    clear_right,
  output logic [tccl_pkg::COORD_W-1:0]    clear_bottom,
  output logic                            glyph_valid,
  output logic [tccl_pkg::COORD_W-1:0]    glyph_x,
  output logic [tccl_pkg::COORD_W-1:0]    glyph_y
);

  tccl_pkg::cmd_t    cmd;
  tccl_pkg::status_t status;

  // Sequence each character
  tccl_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .char_valid   (char_valid),
    .char_stall   (char_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .status       (status),
    .cmd          (cmd)
  );

  // Cursor, stack and result datapath
  tccl_dp #(
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .SCROLL_LINES  (SCROLL_LINES)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .char_code    (char_code),
    .glyph_width  (glyph_width),
    .cmd          (cmd),
    .status       (status),
    .scrolled     (scrolled),
    .clear_valid  (clear_valid),
    .clear_left   (clear_left),
    .clear_top    (clear_top),
    .clear_right  (clear_right),
    .clear_bottom (clear_bottom),
    .glyph_valid  (glyph_valid),
    .glyph_x      (glyph_x),
    .glyph_y      (glyph_y)
  );

  // Checks on the block's own sequencing and results
  `ASSERT_NEXT(a_busy_after_transfer, clk, rst, char_valid && !char_stall, char_stall)
  `ASSERT_IMPLY(a_load_only_when_free, clk, rst, cmd.load_out, !result_valid || !result_stall)
  `ASSERT_IMPLY(a_glyph_has_clear, clk, rst, result_valid && glyph_valid, clear_valid)
  `ASSERT_IMPLY(a_no_rect_is_zero, clk, rst, result_valid && !clear_valid, clear_left == '0 && clear_right == '0)

endmodule

### tb/sv/testbench.sv
// Self-checking testbench for the text console cursor layout block.
`timescale 1ns / 1ps

module testbench;
  import tccl_pkg::*;

  localparam int HIST_DEPTH = 256;
  localparam int SCROLL_N   = 8;

  // One layout result, fields in port order
  typedef struct packed {
    logic               scrolled;
    logic               clear_valid;
    logic [COORD_W-1:0] clear_left;
    logic [COORD_W-1:0] clear_top;
    logic [COORD_W-1:0] clear_right;
    logic [COORD_W-1:0] clear_bottom;
    logic               glyph_valid;
    logic [COORD_W-1:0] glyph_x;
    logic [COORD_W-1:0] glyph_y;
  } layout_t;

  localparam layout_t NOTHING = '0;

  typedef enum logic {ROW_CHAR, ROW_REG} row_kind_t;

  typedef struct {
    row_kind_t             kind;
    logic [CODE_W-1:0]     code;
    logic [GW_W-1:0]       gw;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_val;
    bit                    typed;
    layout_t               want;
  } stim_row_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  char_valid = 1'b0;
  logic                  char_stall;
  logic [CODE_W-1:0]     char_code = '0;
  logic [GW_W-1:0]       glyph_width = '0;
  logic                  result_valid;
  logic                  result_stall = 1'b0;
  logic                  scrolled;
  logic                  clear_valid;
  logic [COORD_W-1:0]    clear_left;
  logic [COORD_W-1:0]    clear_top;
  logic [COORD_W-1:0]    clear_right;
  logic [COORD_W-1:0]    clear_bottom;
  logic                  glyph_valid;
  logic [COORD_W-1:0]    glyph_x;
  logic [COORD_W-1:0]    glyph_y;

  // Window registers and cursor as the block should hold them
  logic [WIN_W-1:0]   win_l, win_r, win_b;
  logic [LH_W-1:0]    line_h, space_w;
  logic [COORD_W-1:0] cur_x, cur_y;
  logic [COORD_W-1:0] x_stack [HIST_DEPTH];
  int                 stack_fill;

  layout_t   awaited_layouts[$];
  stim_row_t dir_rows[$];
  layout_t   rx_got, rx_want;
  int        mismatch_count = 0;
  int        gap_level = 0;
  int        stall_level = 0;
  int        burst_left = 0;
  int        stall_run = 0;

  text_console_cursor_layout #(
    .HISTORY_DEPTH(HIST_DEPTH),
    .SCROLL_LINES (SCROLL_N)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .char_valid  (char_valid),
    .char_stall  (char_stall),
    .char_code   (char_code),
    .glyph_width (glyph_width),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .scrolled    (scrolled),
    .clear_valid (clear_valid),
    .clear_left  (clear_left),
    .clear_top   (clear_top),
    .clear_right (clear_right),
    .clear_bottom(clear_bottom),
    .glyph_valid (glyph_valid),
    .glyph_x     (glyph_x),
    .glyph_y     (glyph_y)
  );

  always #2 clk = ~clk;

  function automatic layout_t mk_layout(input int sc, input int cv, input int cl, input int ct,
                                        input int cr, input int cb, input int gv, input int gx,
                                        input int gy);
    layout_t r;
    r.scrolled     = sc[0];
    r.clear_valid  = cv[0];
    r.clear_left   = cl[COORD_W-1:0];
    r.clear_top    = ct[COORD_W-1:0];
    r.clear_right  = cr[COORD_W-1:0];
    r.clear_bottom = cb[COORD_W-1:0];
    r.glyph_valid  = gv[0];
    r.glyph_x      = gx[COORD_W-1:0];
    r.glyph_y      = gy[COORD_W-1:0];
    return r;
  endfunction

  function automatic string show_layout(input layout_t v);
    return $sformatf("scrolled=%0d clear=%0d (%0d,%0d)-(%0d,%0d) glyph=%0d (%0d,%0d)",
                     v.scrolled, v.clear_valid, v.clear_left, v.clear_top, v.clear_right,
                     v.clear_bottom, v.glyph_valid, v.glyph_x, v.glyph_y);
  endfunction

  function automatic logic [COORD_W-1:0] sat13(input int v);
    if (v < 0) return '0;
    if (v > int'(COORD_MAX)) return COORD_MAX;
    return v[COORD_W-1:0];
  endfunction

  // Move down one line, scrolling first when the next line reaches the bottom bound
  function automatic logic line_feed();
    int   y;
    int   h;
    logic sc;
    y  = int'(cur_y);
    h  = int'(line_h);
    sc = 1'b0;
    if (y + h >= int'(win_b)) begin
      y  = y - SCROLL_N * h;
      sc = 1'b1;
    end
    cur_y      = sat13(y + h);
    stack_fill = 0;
    cur_x      = {1'b0, win_l};
    return sc;
  endfunction

  // Lay out one character and advance the cursor
  function automatic layout_t place_char(input logic [CODE_W-1:0] code,
                                         input logic [GW_W-1:0] gw);
    layout_t r;
    int      x, y, h, w, off, steps;
    r = NOTHING;
    h = int'(line_h);
    if (stack_fill >= HIST_DEPTH) stack_fill = 0;
    if (code == CHAR_NEWLINE) begin
      r.scrolled = line_feed();
    end else if (code == CHAR_RETURN) begin
      stack_fill = 0;
      cur_x      = {1'b0, win_l};
    end else if (code == CHAR_TAB) begin
      w = (space_w == '0) ? 1 : int'(space_w);
      x = int'(cur_x);
      y = int'(cur_y);
      x_stack[stack_fill] = cur_x;
      stack_fill++;
      off = x - int'(win_l);
      if (off < 0) off = 0;
      steps          = TAB_SPACES - ((off / w) % TAB_SPACES);
      r.clear_valid  = 1'b1;
      r.clear_left   = cur_x;
      r.clear_top    = cur_y;
      r.clear_right  = sat13(x + steps * w);
      r.clear_bottom = sat13(y + h);
      cur_x          = r.clear_right;
    end else if (code == CHAR_BACKSPACE) begin
      if (stack_fill > 0) begin
        stack_fill--;
        r.clear_valid  = 1'b1;
        r.clear_left   = x_stack[stack_fill];
        r.clear_top    = cur_y;
        r.clear_right  = cur_x;
        r.clear_bottom = sat13(int'(cur_y) + h);
        cur_x          = r.clear_left;
      end
    end else begin
      // wrap when the glyph would not fit on this line
      if (int'(cur_x) >= int'(win_r) - int'(gw)) r.scrolled = line_feed();
      x = int'(cur_x);
      y = int'(cur_y);
      x_stack[stack_fill] = cur_x;
      stack_fill++;
      r.clear_valid  = 1'b1;
      r.clear_left   = cur_x;
      r.clear_top    = cur_y;
      r.clear_right  = sat13(x + int'(gw));
      r.clear_bottom = sat13(y + h);
      r.glyph_valid  = 1'b1;
      r.glyph_x      = cur_x;
      r.glyph_y      = cur_y;
      cur_x          = r.clear_right;
    end
    return r;
  endfunction

  function automatic stim_row_t chr_row(input logic [CODE_W-1:0] c, input logic [GW_W-1:0] g);
    stim_row_t r;
    r.kind    = ROW_CHAR;
    r.code    = c;
    r.gw      = g;
    r.reg_idx = CFG_WIN_LEFT;
    r.reg_val = '0;
    r.typed   = 1'b0;
    r.want    = NOTHING;
    return r;
  endfunction

  function automatic stim_row_t typed_row(input logic [CODE_W-1:0] c, input logic [GW_W-1:0] g,
                                          input layout_t w);
    stim_row_t r;
    r       = chr_row(c, g);
    r.typed = 1'b1;
    r.want  = w;
    return r;
  endfunction

  function automatic stim_row_t reg_row(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [CFG_DATA_W-1:0] val);
    stim_row_t r;
    r         = chr_row('0, '0);
    r.kind    = ROW_REG;
    r.reg_idx = idx;
    r.reg_val = val;
    return r;
  endfunction

  // Offer one character, hold it until the transfer, then record what it should produce
  task automatic send_char(input logic [CODE_W-1:0] code, input logic [GW_W-1:0] gw,
                           input bit typed, input layout_t want);
    int      gap;
    layout_t predicted;
    gap = 0;
    if (gap_level != 0) begin
      if (burst_left == 0) begin
        gap        = $urandom_range(1, (gap_level == 1) ? 4 : 24);
        burst_left = $urandom_range(1, 16);
      end else begin
        burst_left--;
      end
    end
    cfg_we <= 1'b0;
    if (gap > 0) begin
      char_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    char_valid  <= 1'b1;
    char_code   <= code;
    glyph_width <= gw;
    @(posedge clk);
    while (char_stall) @(posedge clk);
    predicted = place_char(code, gw);
    awaited_layouts.push_back(typed ? want : predicted);
  endtask

  // Hold the sender until every awaited result has arrived
  task automatic drain_results();
    char_valid <= 1'b0;
    while (awaited_layouts.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      CFG_WIN_LEFT:    win_l   = val[WIN_W-1:0];
      CFG_WIN_RIGHT:   win_r   = val[WIN_W-1:0];
      CFG_WIN_BOTTOM:  win_b   = val[WIN_W-1:0];
      CFG_LINE_HEIGHT: line_h  = val[LH_W-1:0];
      CFG_SPACE_WIDTH: space_w = val[LH_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_window(input int l, input int t, input int r, input int b, input int lh,
                            input int sw);
    drain_results();
    write_reg(CFG_WIN_LEFT, l[CFG_DATA_W-1:0]);
    write_reg(CFG_WIN_TOP, t[CFG_DATA_W-1:0]);
    write_reg(CFG_WIN_RIGHT, r[CFG_DATA_W-1:0]);
    write_reg(CFG_WIN_BOTTOM, b[CFG_DATA_W-1:0]);
    write_reg(CFG_LINE_HEIGHT, lh[CFG_DATA_W-1:0]);
    write_reg(CFG_SPACE_WIDTH, sw[CFG_DATA_W-1:0]);
  endtask

  // Random text: mostly printable runs, with tabs, backspaces, line breaks and stray codes
  task automatic run_phase(input int n_items, input bit long_line);
    logic [CODE_W-1:0] code;
    logic [GW_W-1:0]   gw;
    int                pick;
    int                k;
    if (long_line) begin
      // push zero-width glyphs on one line until the x stack runs past its depth
      send_char(CHAR_RETURN, 8'd0, 1'b0, NOTHING);
      for (k = 0; k < HIST_DEPTH + 20; k++) begin
        if (k % 37 == 36) send_char(CHAR_BACKSPACE, 8'd0, 1'b0, NOTHING);
        else send_char(21'($urandom_range(33, 126)), 8'd0, 1'b0, NOTHING);
      end
      repeat (6) send_char(CHAR_BACKSPACE, 8'($urandom_range(0, 255)), 1'b0, NOTHING);
    end
    for (k = 0; k < n_items; k++) begin
      if (k == n_items / 2) drain_results();
      pick = $urandom_range(0, 99);
      gw   = 8'($urandom_range(0, 255));
      if (pick < 55) begin
        code = ($urandom_range(0, 19) == 0) ? 21'($urandom) : 21'($urandom_range(32, 126));
        if ($urandom_range(0, 9) != 0) gw = 8'($urandom_range(1, 24));
      end else if (pick < 65) begin
        code = CHAR_TAB;
      end else if (pick < 80) begin
        code = CHAR_BACKSPACE;
      end else if (pick < 90) begin
        code = CHAR_NEWLINE;
      end else if (pick < 95) begin
        code = CHAR_RETURN;
      end else begin
        code = 21'($urandom_range(0, 15));
      end
      send_char(code, gw, 1'b0, NOTHING);
    end
  endtask

  // Check each result transfer against the oldest awaited layout; drive the result stall
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        rx_got = {scrolled, clear_valid, clear_left, clear_top, clear_right, clear_bottom,
                  glyph_valid, glyph_x, glyph_y};
        if (awaited_layouts.size() == 0) begin
          if (mismatch_count < 10) $display("unexpected result: %s", show_layout(rx_got));
          mismatch_count++;
        end else begin
          rx_want = awaited_layouts.pop_front();
          if (rx_got !== rx_want) begin
            if (mismatch_count < 10) begin
              $display("layout mismatch: expected %s", show_layout(rx_want));
              $display("                 actual   %s", show_layout(rx_got));
            end
            mismatch_count++;
          end
        end
      end
      if (stall_run == 0) begin
        stall_run    <= $urandom_range(1, 12);
        result_stall <= (stall_level != 0) &&
                        ($urandom_range(0, 99) < ((stall_level == 1) ? 25 : 60));
      end else begin
        stall_run <= stall_run - 1;
      end
    end
  end

  initial begin
    #10_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    int ph, wl, wt, wr, wb, wh, ws;
    bit long_line;

    win_l      = RST_WIN_LEFT;
    win_r      = RST_WIN_RIGHT;
    win_b      = RST_WIN_BOTTOM;
    line_h     = RST_LINE_HEIGHT;
    space_w    = RST_SPACE_WIDTH;
    cur_x      = {1'b0, RST_WIN_LEFT};
    cur_y      = {1'b0, RST_WIN_TOP};
    stack_fill = 0;

    // directed rows: reset window first, then the corner cases that need other settings
    dir_rows.push_back(typed_row(CHAR_BACKSPACE, 8'd0, NOTHING));
    dir_rows.push_back(typed_row(21'd65, 8'd8, mk_layout(0, 1, 29, 55, 37, 71, 1, 29, 55)));
    dir_rows.push_back(typed_row(CHAR_BACKSPACE, 8'd0, mk_layout(0, 1, 29, 55, 37, 71, 0, 0, 0)));
    dir_rows.push_back(typed_row(CHAR_TAB, 8'd0, mk_layout(0, 1, 29, 55, 93, 71, 0, 0, 0)));
    dir_rows.push_back(typed_row(CHAR_RETURN, 8'd0, NOTHING));
    dir_rows.push_back(typed_row(CHAR_NEWLINE, 8'd0, NOTHING));
    dir_rows.push_back(typed_row(21'h1FFFFF, 8'd255,
                                 mk_layout(0, 1, 29, 71, 284, 87, 1, 29, 71)));
    dir_rows.push_back(typed_row(21'd0, 8'd255, mk_layout(0, 1, 284, 71, 539, 87, 1, 284, 71)));
    dir_rows.push_back(chr_row(21'd7, 8'd255));
    dir_rows.push_back(chr_row(21'd11, 8'd1));
    dir_rows.push_back(chr_row(21'd12, 8'd2));
    dir_rows.push_back(chr_row(21'd14, 8'd3));
    dir_rows.push_back(chr_row(CHAR_TAB, 8'd255));
    dir_rows.push_back(chr_row(CHAR_BACKSPACE, 8'd255));
    // wide tabs run the cursor into saturation, then a glyph must wrap
    dir_rows.push_back(reg_row(CFG_SPACE_WIDTH, 12'd255));
    repeat (5) dir_rows.push_back(chr_row(CHAR_TAB, 8'd0));
    dir_rows.push_back(chr_row(21'd65, 8'd0));
    // zero space width counts as one pixel
    dir_rows.push_back(reg_row(CFG_SPACE_WIDTH, 12'd0));
    dir_rows.push_back(chr_row(CHAR_TAB, 8'd0));
    // cursor left of the window: the tab advances a full eight spaces
    dir_rows.push_back(reg_row(CFG_WIN_LEFT, 12'd4095));
    dir_rows.push_back(chr_row(CHAR_TAB, 8'd0));
    // scroll with the new line clamped at the top
    dir_rows.push_back(reg_row(CFG_WIN_BOTTOM, 12'd0));
    dir_rows.push_back(reg_row(CFG_LINE_HEIGHT, 12'd255));
    dir_rows.push_back(chr_row(CHAR_NEWLINE, 8'd0));
    dir_rows.push_back(chr_row(CHAR_NEWLINE, 8'd0));
    dir_rows.push_back(chr_row(CHAR_RETURN, 8'd0));

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    gap_level   = 1;
    stall_level = 1;
    foreach (dir_rows[k]) begin
      if (dir_rows[k].kind == ROW_REG) begin
        drain_results();
        write_reg(dir_rows[k].reg_idx, dir_rows[k].reg_val);
      end else begin
        send_char(dir_rows[k].code, dir_rows[k].gw, dir_rows[k].typed, dir_rows[k].want);
      end
    end

    for (ph = 0; ph < 8; ph++) begin
      // typical window by default
      wl = $urandom_range(0, 600);
      wr = wl + $urandom_range(100, 2000);
      wt = $urandom_range(0, 400);
      wb = wt + $urandom_range(50, 1500);
      wh = $urandom_range(1, 40);
      ws = $urandom_range(1, 30);
      long_line = 1'b0;
      case (ph)
        0: begin
          gap_level = 0; stall_level = 0;
        end
        1: begin
          wl = 0; wt = 0; wr = 4095; wb = 4095; wh = 1; ws = 1;
          gap_level = 1; stall_level = 1; long_line = 1'b1;
        end
        2: begin
          wl = 4095; wt = 4095; wr = 0; wb = 0; wh = 255; ws = 255;
          gap_level = 2; stall_level = 2;
        end
        3: begin
          gap_level = 2; stall_level = 0;
        end
        4: begin
          wl = $urandom_range(0, 4095); wt = $urandom_range(0, 4095);
          wr = $urandom_range(0, 4095); wb = $urandom_range(0, 4095);
          wh = $urandom_range(0, 255);  ws = $urandom_range(0, 255);
          gap_level = 0; stall_level = 2;
        end
        5: begin
          wr = wl + $urandom_range(40, 120); wb = wt + $urandom_range(20, 80);
          gap_level = 1; stall_level = 1;
        end
        6: begin
          wl = 29; wr = 4000;
          gap_level = 1; stall_level = 2; long_line = 1'b1;
        end
        default: begin
          gap_level = 2; stall_level = 1;
        end
      endcase
      set_window(wl, wt, wr, wb, wh, ws);
      run_phase(90, long_line);
    end

    drain_results();
    repeat (40) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
